// ===== hdl/bltds_pkg.sv =====
// Shared types and constants for the bar-level two-wire display sender.
// Holds the segment encoding, fixed link bytes and the bar-mask function.
// No dependencies.
`default_nettype none

package bltds_pkg;

    localparam int BAR_COUNT = 10;
    localparam int PCT_STEP  = 10;
    localparam int BYTE_W    = 8;

    localparam logic [BYTE_W-1:0] DATA_CMD_RESET = 8'h44;
    localparam logic [BYTE_W-1:0] DISP_CTL_RESET = 8'h8A;
    localparam logic [BYTE_W-1:0] ADDR_UPPER     = 8'hC0;
    localparam logic [BYTE_W-1:0] ADDR_LOWER     = 8'hC1;

    // Configuration register indexes
    localparam logic CFG_DATA_COMMAND    = 1'b0;
    localparam logic CFG_DISPLAY_CONTROL = 1'b1;

    // Frame numbers within one update sequence
    localparam logic [2:0] FRAME_CMD0  = 3'd0;
    localparam logic [2:0] FRAME_UPPER = 3'd1;
    localparam logic [2:0] FRAME_CMD1  = 3'd2;
    localparam logic [2:0] FRAME_LOWER = 3'd3;
    localparam logic [2:0] FRAME_DISP  = 3'd4;

    // Sub-interval codes
    localparam logic [1:0] SUB_0 = 2'd0;
    localparam logic [1:0] SUB_1 = 2'd1;
    localparam logic [1:0] SUB_2 = 2'd2;
    localparam logic [1:0] SUB_3 = 2'd3;

    localparam logic [2:0] BIT_LAST = 3'd7;

    // Segment of a frame: start condition, data bits, acknowledge slot, stop
    typedef enum logic [3:0] {
        SEG_START = 4'b0001,
        SEG_BIT   = 4'b0010,
        SEG_ACK   = 4'b0100,
        SEG_STOP  = 4'b1000
    } t_seg;

    // Mask bit i is lit when the percent reaches the threshold of bar (10 - i);
    // the mask fills from its top bit. Negative percents light nothing.
    function automatic logic [BAR_COUNT-1:0] bar_mask(input logic signed [7:0] pct);
        logic [BAR_COUNT-1:0] m;
        for (int i = 0; i < BAR_COUNT; i++) begin
            m[i] = (pct >= $signed(8'(PCT_STEP * (BAR_COUNT - i))));
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/bar_level_two_wire_display_sender_core.sv =====
// Bar-level sender for a two-wire LED bar-graph driver: latches a level and
// plays the five-frame update sequence one pin interval per tick beat.
// Depends on bltds_pkg.
//
// A new input beat is accepted in every cycle while
// the result register is empty or being drained. A level beat while idle
// latches the bar bytes and starts a 224-interval sequence; each tick beat
// then yields one result beat from a frame/segment/bit/sub-interval counter
// set. Level beats while busy and tick beats while idle give no result. The
// configuration port is always ready and takes one write per cycle.
`default_nettype none

module bar_level_two_wire_display_sender_core
    import bltds_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,

    input  wire logic              i_cfg_valid,
    output      logic              o_cfg_ready,
    input  wire logic              i_cfg_index,
    input  wire logic [BYTE_W-1:0] i_cfg_data,

    input  wire logic              i_in_valid,
    output      logic              o_in_ready,
    input  wire logic              i_mode,
    input  wire logic signed [7:0] i_percent,

    output      logic              o_out_valid,
    input  wire logic              i_out_ready,
    output      logic              o_clock_line,
    output      logic              o_data_line,
    output      logic              o_data_drive,
    output      logic              o_sequence_last
);

    logic [BYTE_W-1:0] r_data_cmd, r_disp_ctl;
    logic [BYTE_W-1:0] r_upper, r_lower, n_upper, n_lower;
    logic              r_busy, n_busy;
    logic              r_data_level, n_data_level;
    t_seg              r_seg, n_seg;
    logic [2:0]        r_frame, n_frame;
    logic              r_byte, n_byte;
    logic [2:0]        r_bit, n_bit;
    logic [1:0]        r_sub, n_sub;

    logic r_out_valid, n_out_valid;
    logic r_clk, r_dat, r_drv, r_last;
    logic n_clk, n_dat, n_drv, n_last;

    logic              in_fire, tick_fire, level_fire;
    logic              two_bytes;
    logic [BYTE_W-1:0] cur_byte;
    logic [BAR_COUNT-1:0] mask;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_fire     = i_in_valid && o_in_ready;
    assign tick_fire   = in_fire && i_mode && r_busy;
    assign level_fire  = in_fire && !i_mode && !r_busy;

    assign mask = bar_mask(i_percent);

    assign two_bytes = (r_frame == FRAME_UPPER) || (r_frame == FRAME_LOWER);

    always_comb begin
        unique case (r_frame) inside
            FRAME_UPPER:            cur_byte = r_byte ? r_upper : ADDR_UPPER;
            FRAME_LOWER:            cur_byte = r_byte ? r_lower : ADDR_LOWER;
            FRAME_CMD0, FRAME_CMD1: cur_byte = r_data_cmd;
            default:                cur_byte = r_disp_ctl;
        endcase
    end

    // Pin decode and counter advance for the current interval
    always_comb begin
        n_clk   = 1'b0;
        n_dat   = r_data_level;
        n_drv   = 1'b1;
        n_last  = 1'b0;
        n_seg   = r_seg;
        n_frame = r_frame;
        n_byte  = r_byte;
        n_bit   = r_bit;
        n_sub   = r_sub + 2'd1;
        n_busy  = r_busy;
        unique case (r_seg)
            SEG_START: begin
                n_clk = (r_sub != SUB_2);
                n_dat = (r_sub == SUB_0);
                if (r_sub == SUB_2) begin
                    n_seg  = SEG_BIT;
                    n_byte = 1'b0;
                    n_bit  = '0;
                    n_sub  = SUB_0;
                end
            end
            SEG_BIT: begin
                n_clk = (r_sub == SUB_2);
                // hold the previous level on the first interval of each bit
                if (r_sub != SUB_0) begin
                    n_dat = cur_byte[r_bit];
                end
                if (r_sub == SUB_2) begin
                    n_sub = SUB_0;
                    if (r_bit == BIT_LAST) begin
                        n_seg = SEG_ACK;
                    end else begin
                        n_bit = r_bit + 3'd1;
                    end
                end
            end
            SEG_ACK: begin
                n_clk = (r_sub == SUB_1);
                n_dat = 1'b0;
                n_drv = (r_sub == SUB_2);
                if (r_sub == SUB_2) begin
                    n_sub = SUB_0;
                    n_bit = '0;
                    if (two_bytes && !r_byte) begin
                        n_seg  = SEG_BIT;
                        n_byte = 1'b1;
                    end else begin
                        n_seg = SEG_STOP;
                    end
                end
            end
            SEG_STOP: begin
                case (r_sub)
                    SUB_0:   n_clk = 1'b0;
                    SUB_1:   begin n_clk = 1'b0; n_dat = 1'b0; end
                    SUB_2:   begin n_clk = 1'b1; n_dat = 1'b0; end
                    default: begin n_clk = 1'b1; n_dat = 1'b1; end
                endcase
                if (r_sub == SUB_3) begin
                    n_sub  = SUB_0;
                    n_seg  = SEG_START;
                    n_byte = 1'b0;
                    if (r_frame == FRAME_DISP) begin
                        n_last  = 1'b1;
                        n_busy  = 1'b0;
                        n_frame = FRAME_CMD0;
                    end else begin
                        n_frame = r_frame + 3'd1;
                    end
                end
            end
            default: begin
                n_seg = SEG_START;
                n_sub = SUB_0;
            end
        endcase
        n_data_level = n_drv ? n_dat : r_data_level;
        n_upper      = mask[BAR_COUNT-1:2];
        n_lower      = {mask[1:0], 6'b0};
        n_out_valid  = tick_fire ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_cmd   <= DATA_CMD_RESET;
            r_disp_ctl   <= DISP_CTL_RESET;
            r_busy       <= 1'b0;
            r_data_level <= 1'b1;
            r_seg        <= SEG_START;
            r_frame      <= FRAME_CMD0;
            r_byte       <= 1'b0;
            r_bit        <= '0;
            r_sub        <= SUB_0;
            r_upper      <= '0;
            r_lower      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_DATA_COMMAND) begin
                    r_data_cmd <= i_cfg_data;
                end
                if (i_cfg_index == CFG_DISPLAY_CONTROL) begin
                    r_disp_ctl <= i_cfg_data;
                end
            end
            if (level_fire) begin
                r_upper <= n_upper;
                r_lower <= n_lower;
                r_busy  <= 1'b1;
            end else if (tick_fire) begin
                r_busy       <= n_busy;
                r_data_level <= n_data_level;
                r_seg        <= n_seg;
                r_frame      <= n_frame;
                r_byte       <= n_byte;
                r_bit        <= n_bit;
                r_sub        <= n_sub;
            end
            r_out_valid <= n_out_valid;
        end
    end

    // Result register payload
    always_ff @(posedge i_clk) begin
        if (tick_fire) begin
            r_clk  <= n_clk;
            r_dat  <= n_dat;
            r_drv  <= n_drv;
            r_last <= n_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_clock_line    = r_clk;
    assign o_data_line     = r_dat;
    assign o_data_drive    = r_drv;
    assign o_sequence_last = r_last;

    a_seg_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_seg))
        else $error("segment state not one-hot");

    a_idle_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_frame == FRAME_CMD0 && r_seg == SEG_START && r_sub == SUB_0))
        else $error("sequencer counters not cleared while idle");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tick_fire && n_last) |=> !r_busy)
        else $error("busy still set after final interval");

    a_level_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        level_fire |=> r_busy)
        else $error("level beat while idle did not start a sequence");

    a_released_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_data_drive) |-> !o_data_line)
        else $error("released data beat carries a high level");

endmodule

`default_nettype wire

// ===== test/bltds_link_checker.sv =====
// Scoreboard for the bar-level two-wire display sender: follows register
// writes and input beats, predicts every pin-level result and checks the
// output channel against it. Depends on bltds_pkg.

module bltds_link_checker
    import bltds_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,

    input  wire logic              i_cfg_valid,
    input  wire logic              i_cfg_ready,
    input  wire logic              i_cfg_index,
    input  wire logic [BYTE_W-1:0] i_cfg_data,

    input  wire logic              i_in_valid,
    input  wire logic              i_in_ready,
    input  wire logic              i_mode,
    input  wire logic signed [7:0] i_percent,

    input  wire logic              i_out_valid,
    input  wire logic              i_out_ready,
    input  wire logic              i_clock_line,
    input  wire logic              i_data_line,
    input  wire logic              i_data_drive,
    input  wire logic              i_sequence_last,

    output      int                o_fail_count,
    output      int                o_pending
);

    localparam int SEQ_LEN = 224;

    typedef struct packed {
        logic clock_line;
        logic data_line;
        logic data_drive;
        logic sequence_last;
    } t_pin_beat;

    logic [BYTE_W-1:0] data_cmd;
    logic [BYTE_W-1:0] disp_ctl;
    logic [BYTE_W-1:0] upper_bars;
    logic [BYTE_W-1:0] lower_bars;
    logic              sending;
    int                interval;
    logic              held_data;
    t_pin_beat         pin_beats_q[$];
    int                errors = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic logic [BYTE_W-1:0] frame_byte_at(input logic [2:0] frame, input int idx);
        case (frame)
            FRAME_CMD0, FRAME_CMD1: return data_cmd;
            FRAME_UPPER:            return (idx == 0) ? ADDR_UPPER : upper_bars;
            FRAME_LOWER:            return (idx == 0) ? ADDR_LOWER : lower_bars;
            default:                return disp_ctl;
        endcase
    endfunction

    // Pin levels of one interval of the update sequence.
    function automatic t_pin_beat pins_for_interval(input int ph);
        t_pin_beat         beat;
        int                p;
        int                nbytes;
        int                flen;
        int                r;
        int                sub;
        logic [2:0]        frame;
        logic [BYTE_W-1:0] byt;
        beat.clock_line    = 1'b0;
        beat.data_line     = held_data;
        beat.data_drive    = 1'b1;
        beat.sequence_last = (ph == SEQ_LEN - 1);
        p = ph;
        for (int f = 0; f < 5; f++) begin
            frame  = f[2:0];
            nbytes = (frame == FRAME_UPPER || frame == FRAME_LOWER) ? 2 : 1;
            flen   = 7 + 27 * nbytes;
            if (p >= flen) begin
                p -= flen;
            end else begin
                if (p < 3) begin
                    // start: data drops while clock is high
                    beat.clock_line = (p != 2);
                    beat.data_line  = (p == 0);
                end else if (p < 3 + 27 * nbytes) begin
                    p -= 3;
                    r = p % 27;
                    if (r < 24) begin
                        byt = frame_byte_at(frame, p / 27);
                        sub = r % 3;
                        beat.clock_line = (sub == 2);
                        // hold the previous level on the first interval of a bit
                        if (sub != 0) begin
                            beat.data_line = byt[r / 3];
                        end
                    end else begin
                        // acknowledge slot: release for two intervals, then drive low
                        sub = r - 24;
                        beat.clock_line = (sub == 1);
                        beat.data_line  = 1'b0;
                        beat.data_drive = (sub == 2);
                    end
                end else begin
                    p -= 3 + 27 * nbytes;
                    beat.clock_line = (p >= 2);
                    if (p == 1 || p == 2) begin
                        beat.data_line = 1'b0;
                    end else if (p >= 3) begin
                        beat.data_line = 1'b1;
                    end
                end
                return beat;
            end
        end
        return beat;
    endfunction

    function automatic void check_bit(input string field, input logic want_bit,
                                      input logic got_bit);
        if (got_bit !== want_bit) begin
            errors++;
            $display("%0t: %s expected %0b got %0b", $time, field, want_bit, got_bit);
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_pin_beat  want;
        logic [9:0] mask;
        int         pct;
        if (!i_rst_n) begin
            data_cmd   = DATA_CMD_RESET;
            disp_ctl   = DISP_CTL_RESET;
            upper_bars = '0;
            lower_bars = '0;
            sending    = 1'b0;
            interval   = 0;
            held_data  = 1'b1;
            pin_beats_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (pin_beats_q.size() == 0) begin
                    errors++;
                    $display("%0t: result beat expected none got clk %0b data %0b drive %0b last %0b",
                             $time, i_clock_line, i_data_line, i_data_drive, i_sequence_last);
                end else begin
                    want = pin_beats_q.pop_front();
                    check_bit("clock_line", want.clock_line, i_clock_line);
                    check_bit("data_line", want.data_line, i_data_line);
                    check_bit("data_drive", want.data_drive, i_data_drive);
                    check_bit("sequence_last", want.sequence_last, i_sequence_last);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_DATA_COMMAND) begin
                    data_cmd = i_cfg_data;
                end else begin
                    disp_ctl = i_cfg_data;
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (!i_mode) begin
                    // level beat: latch only when idle, drop while sending
                    if (!sending) begin
                        pct = i_percent;
                        if (pct < 0) begin
                            pct = 0;
                        end
                        if (pct > 100) begin
                            pct = 100;
                        end
                        mask       = 10'h3FF << (BAR_COUNT - pct / PCT_STEP);
                        upper_bars = mask[9:2];
                        lower_bars = {mask[1:0], 6'b0};
                        sending    = 1'b1;
                        interval   = 0;
                    end
                end else if (sending) begin
                    want = pins_for_interval(interval);
                    if (want.data_drive) begin
                        held_data = want.data_line;
                    end
                    pin_beats_q.push_back(want);
                    if (want.sequence_last) begin
                        sending  = 1'b0;
                        interval = 0;
                    end else begin
                        interval++;
                    end
                end
            end
        end
        o_fail_count <= errors;
        o_pending    <= pin_beats_q.size();
    end

endmodule

// ===== test/tb_top.sv =====
// Testbench top for the bar-level two-wire display sender: drives reset,
// register writes and level/tick beats under varied idling, and gives the
// verdict. Depends on bltds_pkg and bltds_link_checker.

module tb_top;
    import bltds_pkg::*;

    localparam logic MODE_LEVEL    = 1'b0;
    localparam logic MODE_TICK     = 1'b1;
    localparam int   SEQ_LEN       = 224;
    localparam int   LONG_HOLD     = 400;
    localparam int   STALL_LIMIT   = 2000;
    localparam int   SETTLE_CYCLES = 4;
    localparam int   END_CYCLES    = 20;

    logic                     clk;
    logic                     rst_n      = 1'b0;
    logic                     cfg_valid  = 1'b0;
    logic                     cfg_ready;
    logic                     cfg_index  = CFG_DATA_COMMAND;
    logic        [BYTE_W-1:0] cfg_data   = '0;
    logic                     in_valid   = 1'b0;
    logic                     in_ready;
    logic                     mode       = MODE_LEVEL;
    logic signed [7:0]        percent    = '0;
    logic                     out_valid;
    logic                     out_ready  = 1'b0;
    logic                     clock_line;
    logic                     data_line;
    logic                     data_drive;
    logic                     sequence_last;
    int                       fail_count;
    int                       pending;

    int   sender_idle_pct = 0;
    int   recv_stall_pct  = 0;
    logic hold_req        = 1'b0;
    logic hold_taken      = 1'b0;
    int   hold_left       = 0;
    int   quiet_cycles    = 0;

    bar_level_two_wire_display_sender_core i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_mode          (mode),
        .i_percent       (percent),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_clock_line    (clock_line),
        .o_data_line     (data_line),
        .o_data_drive    (data_drive),
        .o_sequence_last (sequence_last)
    );

    bltds_link_checker i_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_mode          (mode),
        .i_percent       (percent),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_clock_line    (clock_line),
        .i_data_line     (data_line),
        .i_data_drive    (data_drive),
        .i_sequence_last (sequence_last),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Receiver: random stalls, plus one long hold-off on request.
    always @(posedge clk) begin
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = LONG_HOLD;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: end the run when no channel moves a beat for too long.
    always @(posedge clk) begin
        if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_beat(input logic m, input logic [7:0] p);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        percent  <= p;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic write_config(input logic [BYTE_W-1:0] cmd, input logic [BYTE_W-1:0] ctl);
        for (int k = 0; k < 2; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= (k == 0) ? CFG_DATA_COMMAND : CFG_DISPLAY_CONTROL;
            cfg_data  <= (k == 0) ? cmd : ctl;
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    // Drop valid, then wait until every predicted result has been taken.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One level beat and a full run of ticks; noisy adds stray beats.
    task automatic play_update(input logic [7:0] level_pct, input logic noisy);
        int ticks;
        ticks = 0;
        if (noisy) begin
            while ($urandom_range(7) == 0) send_beat(MODE_TICK, 8'($urandom_range(255)));
        end
        send_beat(MODE_LEVEL, level_pct);
        while (ticks < SEQ_LEN) begin
            if (noisy && $urandom_range(39) == 0) begin
                send_beat(MODE_LEVEL, 8'($urandom_range(255)));
            end else begin
                send_beat(MODE_TICK, 8'($urandom_range(255)));
                ticks++;
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: idle tick, extremes of the percent, a level dropped while busy.
        send_beat(MODE_TICK, 8'h80);
        send_beat(MODE_LEVEL, 8'h80);
        send_beat(MODE_LEVEL, 8'h7F);
        repeat (SEQ_LEN) send_beat(MODE_TICK, 8'($urandom_range(255)));

        for (int ph = 0; ph < 4; ph++) begin
            wait_drained();
            case (ph)
                0: begin
                    write_config(8'h00, 8'hFF);
                    sender_idle_pct = 0;
                    recv_stall_pct  = 0;
                    hold_req <= 1'b1;
                end
                1: begin
                    write_config(8'hFF, 8'h00);
                    sender_idle_pct = 57;
                    recv_stall_pct  = 0;
                end
                2: begin
                    write_config(8'($urandom_range(255)), 8'($urandom_range(255)));
                    sender_idle_pct = 0;
                    recv_stall_pct  = 57;
                end
                default: begin
                    write_config(8'hA5, 8'h5A);
                    sender_idle_pct = 8;
                    recv_stall_pct  = 8;
                end
            endcase
            if ($urandom_range(1) == 0) begin
                play_update(8'($urandom_range(255)), 1'b1);
            end else begin
                play_update(8'($urandom_range(100)), 1'b1);
            end
        end

        wait_drained();
        repeat (END_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== bar_level_two_wire_display_sender_core.f =====
hdl/bltds_pkg.sv
hdl/bar_level_two_wire_display_sender_core.sv
test/bltds_link_checker.sv
test/tb_top.sv
